// File: hdl/ttsc_pkg.sv
// Shared widths, codes, reset values and pipeline types for the touch coordinate mapper.
package ttsc_pkg;

  localparam int SAMPLE_BITS   = 8;
  localparam int DIM_BITS      = 12;
  localparam int PROD_BITS     = SAMPLE_BITS + DIM_BITS;
  localparam int DIV_STEPS     = 2;
  localparam int DIV_STAGES    = (DIM_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int LATENCY       = DIV_STAGES + 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (DIM_BITS > SAMPLE_BITS) ? DIM_BITS : SAMPLE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIENTATION   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL_MIN_X     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL_MAX_X     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL_MIN_Y     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL_MAX_Y     = 3'd6;

  localparam logic [1:0] ORIENT_PORTRAIT          = 2'd0;
  localparam logic [1:0] ORIENT_LANDSCAPE         = 2'd1;
  localparam logic [1:0] ORIENT_PORTRAIT_FLIPPED  = 2'd2;
  localparam logic [1:0] ORIENT_LANDSCAPE_FLIPPED = 2'd3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [DIM_BITS-1:0]    dim_t;
  typedef logic [PROD_BITS-1:0]   prod_t;

  localparam dim_t    RST_SCREEN_WIDTH  = DIM_BITS'(320);
  localparam dim_t    RST_SCREEN_HEIGHT = DIM_BITS'(240);
  localparam logic [1:0] RST_ORIENTATION = ORIENT_PORTRAIT;
  localparam sample_t RST_CAL_MIN_X     = SAMPLE_BITS'(10);
  localparam sample_t RST_CAL_MAX_X     = SAMPLE_BITS'(110);
  localparam sample_t RST_CAL_MIN_Y     = SAMPLE_BITS'(5);
  localparam sample_t RST_CAL_MAX_Y     = SAMPLE_BITS'(120);

  typedef struct packed {
    dim_t       w;
    dim_t       h;
    logic [1:0] orient;
  } route_t;

  typedef struct packed {
    sample_t off_x;
    sample_t off_y;
    sample_t div_x;
    sample_t div_y;
    dim_t    dim_x;
    dim_t    dim_y;
    route_t  route;
  } prep_t;

  typedef struct packed {
    prod_t   prod_x;
    prod_t   prod_y;
    sample_t div_x;
    sample_t div_y;
    dim_t    dim_x;
    dim_t    dim_y;
    route_t  route;
  } mult_t;

  typedef struct packed {
    sample_t rem;
    dim_t    num;
    dim_t    quo;
  } div_axis_t;

  typedef struct packed {
    div_axis_t ax;
    div_axis_t ay;
    sample_t   div_x;
    sample_t   div_y;
    dim_t      dim_x;
    dim_t      dim_y;
    route_t    route;
  } div_stage_t;

  function automatic div_axis_t div_step(div_axis_t a, sample_t d);
    logic [SAMPLE_BITS:0] trial;
    div_axis_t            r;
    trial = {a.rem, a.num[DIM_BITS-1]};
    r.num = {a.num[DIM_BITS-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      trial = trial - {1'b0, d};
      r.quo = {a.quo[DIM_BITS-2:0], 1'b1};
    end else begin
      r.quo = {a.quo[DIM_BITS-2:0], 1'b0};
    end
    r.rem = trial[SAMPLE_BITS-1:0];
    return r;
  endfunction

endpackage

// File: hdl/touch_to_screen_coord_map.sv
// Top level: pipelined mapping of raw touch samples to clamped screen pixel coordinates.
//
// Usage:
//   Command side: raise start_i with raw_x_i/raw_y_i; a beat is taken at a rising edge
//   with start_i high and busy_o low. busy_o stays low, so a beat may enter every cycle.
//   Result side: result_valid_o marks screen_x_o/screen_y_o for exactly one cycle.
//   A sample outside its calibration window, or a window whose max is not above its
//   min, yields no result beat; every other sample yields exactly one.
//   Pipeline: a result passes through one register stage for the window check, one for
//   the multiply, six for the restoring divider at two quotient bits per stage, and one
//   for mirror and clamp. Throughput: one beat per cycle, set by the fully
//   pipelined divider.
//   Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is high, only
//   while no beat is in flight; indices beyond the list are ignored.
//   Reset: all beats in flight are dropped and registers return to their defaults.
//   The receiver cannot stall; results are never held back.
module touch_to_screen_coord_map (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [ttsc_pkg::SAMPLE_BITS-1:0]    raw_x_i,
  input  logic [ttsc_pkg::SAMPLE_BITS-1:0]    raw_y_i,
  input  logic                                cfg_we_i,
  input  logic [ttsc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [ttsc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output logic                                result_valid_o,
  output logic [ttsc_pkg::DIM_BITS-1:0]       screen_x_o,
  output logic [ttsc_pkg::DIM_BITS-1:0]       screen_y_o
);

  ttsc_pkg::dim_t    width_q, height_q;
  logic [1:0]        orient_q;
  ttsc_pkg::sample_t min_x_q, max_x_q, min_y_q, max_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ttsc_pkg::RST_SCREEN_WIDTH;
      height_q <= ttsc_pkg::RST_SCREEN_HEIGHT;
      orient_q <= ttsc_pkg::RST_ORIENTATION;
      min_x_q  <= ttsc_pkg::RST_CAL_MIN_X;
      max_x_q  <= ttsc_pkg::RST_CAL_MAX_X;
      min_y_q  <= ttsc_pkg::RST_CAL_MIN_Y;
      max_y_q  <= ttsc_pkg::RST_CAL_MAX_Y;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttsc_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data_i[ttsc_pkg::DIM_BITS-1:0];
        ttsc_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data_i[ttsc_pkg::DIM_BITS-1:0];
        ttsc_pkg::REG_ORIENTATION:   orient_q <= cfg_data_i[1:0];
        ttsc_pkg::REG_CAL_MIN_X:     min_x_q  <= cfg_data_i[ttsc_pkg::SAMPLE_BITS-1:0];
        ttsc_pkg::REG_CAL_MAX_X:     max_x_q  <= cfg_data_i[ttsc_pkg::SAMPLE_BITS-1:0];
        ttsc_pkg::REG_CAL_MIN_Y:     min_y_q  <= cfg_data_i[ttsc_pkg::SAMPLE_BITS-1:0];
        ttsc_pkg::REG_CAL_MAX_Y:     max_y_q  <= cfg_data_i[ttsc_pkg::SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  logic win_ok;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign win_ok = (max_x_q > min_x_q) && (max_y_q > min_y_q)
               && (raw_x_i >= min_x_q) && (raw_x_i <= max_x_q)
               && (raw_y_i >= min_y_q) && (raw_y_i <= max_y_q);

  ttsc_pkg::prep_t      prep_d, prep_q;
  ttsc_pkg::mult_t      mult_d, mult_q;
  ttsc_pkg::div_stage_t div_d [ttsc_pkg::DIV_STAGES];
  ttsc_pkg::div_stage_t div_q [ttsc_pkg::DIV_STAGES];
  logic                 prep_vld_d, prep_vld_q, mult_vld_q;
  logic [ttsc_pkg::DIV_STAGES-1:0] div_vld_d, div_vld_q;
  logic                 res_vld_q;
  ttsc_pkg::dim_t       res_x_d, res_y_d, res_x_q, res_y_q;

  always_comb begin
    prep_vld_d         = accept && win_ok;
    prep_d.off_x       = max_x_q - raw_x_i;
    prep_d.off_y       = max_y_q - raw_y_i;
    prep_d.div_x       = max_x_q - min_x_q;
    prep_d.div_y       = max_y_q - min_y_q;
    prep_d.dim_x       = orient_q[0] ? height_q : width_q;
    prep_d.dim_y       = orient_q[0] ? width_q : height_q;
    prep_d.route.w     = width_q;
    prep_d.route.h     = height_q;
    prep_d.route.orient = orient_q;
  end

  always_comb begin
    mult_d.prod_x = ttsc_pkg::PROD_BITS'(prep_q.off_x) * ttsc_pkg::PROD_BITS'(prep_q.dim_x);
    mult_d.prod_y = ttsc_pkg::PROD_BITS'(prep_q.off_y) * ttsc_pkg::PROD_BITS'(prep_q.dim_y);
    mult_d.div_x  = prep_q.div_x;
    mult_d.div_y  = prep_q.div_y;
    mult_d.dim_x  = prep_q.dim_x;
    mult_d.dim_y  = prep_q.dim_y;
    mult_d.route  = prep_q.route;
  end

  always_comb begin
    ttsc_pkg::div_stage_t cur;
    for (int k = 0; k < ttsc_pkg::DIV_STAGES; k++) begin
      if (k == 0) begin
        cur.ax.rem   = mult_q.prod_x[ttsc_pkg::PROD_BITS-1:ttsc_pkg::DIM_BITS];
        cur.ax.num   = mult_q.prod_x[ttsc_pkg::DIM_BITS-1:0];
        cur.ax.quo   = '0;
        cur.ay.rem   = mult_q.prod_y[ttsc_pkg::PROD_BITS-1:ttsc_pkg::DIM_BITS];
        cur.ay.num   = mult_q.prod_y[ttsc_pkg::DIM_BITS-1:0];
        cur.ay.quo   = '0;
        cur.div_x    = mult_q.div_x;
        cur.div_y    = mult_q.div_y;
        cur.dim_x    = mult_q.dim_x;
        cur.dim_y    = mult_q.dim_y;
        cur.route    = mult_q.route;
        div_vld_d[k] = mult_vld_q;
      end else begin
        cur          = div_q[k-1];
        div_vld_d[k] = div_vld_q[k-1];
      end
      for (int s = 0; s < ttsc_pkg::DIV_STEPS; s++) begin
        if (k * ttsc_pkg::DIV_STEPS + s < ttsc_pkg::DIM_BITS) begin
          cur.ax = ttsc_pkg::div_step(cur.ax, cur.div_x);
          cur.ay = ttsc_pkg::div_step(cur.ay, cur.div_y);
        end
      end
      div_d[k] = cur;
    end
  end

  always_comb begin
    ttsc_pkg::div_stage_t last;
    ttsc_pkg::dim_t       vx, vy, mx, my;
    logic                 mir_x, mir_y;
    last  = div_q[ttsc_pkg::DIV_STAGES-1];
    vx    = last.route.orient[0] ? last.ay.quo : last.ax.quo;
    vy    = last.route.orient[0] ? last.ax.quo : last.ay.quo;
    mir_x = (last.route.orient == ttsc_pkg::ORIENT_PORTRAIT)
         || (last.route.orient == ttsc_pkg::ORIENT_LANDSCAPE_FLIPPED);
    mir_y = (last.route.orient == ttsc_pkg::ORIENT_PORTRAIT_FLIPPED)
         || (last.route.orient == ttsc_pkg::ORIENT_LANDSCAPE_FLIPPED);
    mx    = mir_x ? (last.route.w - vx) : vx;
    my    = mir_y ? (last.route.h - vy) : vy;
    if (last.route.w == '0) begin
      res_x_d = '0;
    end else if (mx >= last.route.w) begin
      res_x_d = last.route.w - ttsc_pkg::DIM_BITS'(1);
    end else begin
      res_x_d = mx;
    end
    if (last.route.h == '0) begin
      res_y_d = '0;
    end else if (my >= last.route.h) begin
      res_y_d = last.route.h - ttsc_pkg::DIM_BITS'(1);
    end else begin
      res_y_d = my;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
      mult_vld_q <= 1'b0;
      div_vld_q  <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      prep_vld_q <= prep_vld_d;
      mult_vld_q <= prep_vld_q;
      div_vld_q  <= div_vld_d;
      res_vld_q  <= div_vld_q[ttsc_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q  <= prep_d;
    mult_q  <= mult_d;
    div_q   <= div_d;
    res_x_q <= res_x_d;
    res_y_q <= res_y_d;
  end

  assign result_valid_o = res_vld_q;
  assign screen_x_o     = res_x_q;
  assign screen_y_o     = res_y_q;

  localparam int LAT = ttsc_pkg::LATENCY;

  a_reject_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !win_ok) |-> ##LAT !result_valid_o)
    else $error("rejected sample produced a result beat");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && win_ok) |-> ##LAT result_valid_o)
    else $error("in-window sample lost in pipeline");

  a_quotient_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld_q[ttsc_pkg::DIV_STAGES-1] |->
      (div_q[ttsc_pkg::DIV_STAGES-1].ax.quo <= div_q[ttsc_pkg::DIV_STAGES-1].dim_x)
      && (div_q[ttsc_pkg::DIV_STAGES-1].ay.quo <= div_q[ttsc_pkg::DIV_STAGES-1].dim_y))
    else $error("divider quotient exceeds screen dimension");

endmodule
